### src/lpof_pkg.sv
// shared types, constants and whitelist tables for the length-prefixed opcode filter
// no dependencies; imported by every module of the block
package lpof_pkg;

	localparam int OPCODE_BYTES  = 10;
	localparam int LENGTH_BITS   = 16;
	localparam int CFG_BITS      = 16;
	localparam int CFG_IDX_BITS  = 1;
	localparam int VAL_BITS      = LENGTH_BITS + 4;
	localparam int OPC_IDX_BITS  = $clog2(OPCODE_BYTES);
	localparam int OPC_LEN_BITS  = $clog2(OPCODE_BYTES + 1);
	localparam int ALLOWED_COUNT = 18;
	localparam int BLOB_ENTRY    = 8;

	localparam logic [VAL_BITS-1:0] LEN_MAX = VAL_BITS'((1 << LENGTH_BITS) - 1);
	localparam logic [CFG_BITS-1:0] LIMIT_RESET = CFG_BITS'(4096);

	// stream characters
	localparam logic [7:0] CH_DOT   = 8'h2e;
	localparam logic [7:0] CH_COMMA = 8'h2c;
	localparam logic [7:0] CH_SEMI  = 8'h3b;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	// configuration register indexes
	localparam logic [CFG_IDX_BITS-1:0] REG_ELEMENT_LIMIT = 1'b0;
	localparam logic [CFG_IDX_BITS-1:0] REG_BLOB_LIMIT    = 1'b1;

	typedef enum logic [1:0] {
		PH_LENGTH = 2'd0,
		PH_DATA   = 2'd1,
		PH_DELIM  = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		ST_READY   = 2'd0,
		ST_PARSING = 2'd1,
		ST_INVALID = 2'd2,
		ST_DENIED  = 2'd3
	} status_t;

	typedef struct packed {
		phase_t                 phase;
		logic [LENGTH_BITS-1:0] length_value;
		logic                   length_seen;
		logic [LENGTH_BITS-1:0] bytes_consumed;
		logic                   expecting_opcode;
		logic                   blob_limit_active;
		status_t                fault;
	} parse_state_t;

	typedef struct packed {
		logic                    we;
		logic [OPC_IDX_BITS-1:0] idx;
		logic [7:0]              data;
	} store_wr_t;

	typedef struct packed {
		logic allowed;
		logic is_blob;
	} opc_match_t;

	typedef struct packed {
		status_t status;
		logic    accepted;
		logic    done;
	} step_result_t;

	typedef logic [OPCODE_BYTES-1:0][7:0] opc_store_t;

	// whitelist text, right aligned with the first character highest
	localparam logic [OPCODE_BYTES*8-1:0] ALLOWED_TEXT [ALLOWED_COUNT] = '{
		(OPCODE_BYTES*8)'("key"), (OPCODE_BYTES*8)'("ack"),
		(OPCODE_BYTES*8)'("nop"), (OPCODE_BYTES*8)'("end"),
		(OPCODE_BYTES*8)'("size"), (OPCODE_BYTES*8)'("name"),
		(OPCODE_BYTES*8)'("argv"), (OPCODE_BYTES*8)'("sync"),
		(OPCODE_BYTES*8)'("blob"), (OPCODE_BYTES*8)'("audio"),
		(OPCODE_BYTES*8)'("video"), (OPCODE_BYTES*8)'("image"),
		(OPCODE_BYTES*8)'("mouse"), (OPCODE_BYTES*8)'("select"),
		(OPCODE_BYTES*8)'("connect"), (OPCODE_BYTES*8)'("timezone"),
		(OPCODE_BYTES*8)'("clipboard"), (OPCODE_BYTES*8)'("disconnect")
	};

	localparam logic [OPC_LEN_BITS-1:0] ALLOWED_LEN [ALLOWED_COUNT] = '{
		OPC_LEN_BITS'(3), OPC_LEN_BITS'(3), OPC_LEN_BITS'(3), OPC_LEN_BITS'(3),
		OPC_LEN_BITS'(4), OPC_LEN_BITS'(4), OPC_LEN_BITS'(4), OPC_LEN_BITS'(4),
		OPC_LEN_BITS'(4), OPC_LEN_BITS'(5), OPC_LEN_BITS'(5), OPC_LEN_BITS'(5),
		OPC_LEN_BITS'(5), OPC_LEN_BITS'(6), OPC_LEN_BITS'(7), OPC_LEN_BITS'(8),
		OPC_LEN_BITS'(9), OPC_LEN_BITS'(10)
	};

	// character k of whitelist entry e, zero past its end
	function automatic logic [7:0] opc_char(input int e, input int k);
		int len;
		len = int'(ALLOWED_LEN[e]);
		if (k < len) begin
			return ALLOWED_TEXT[e][(len - 1 - k) * 8 +: 8];
		end
		return 8'h00;
	endfunction

endpackage

### src/lpof_opcode_match.sv
// whitelist compare of the stored opcode bytes against the fixed opcode table
// depends on lpof_pkg
module lpof_opcode_match
	import lpof_pkg::*;
(
	input  opc_store_t             store,
	input  logic [LENGTH_BITS-1:0] length_value,
	output opc_match_t             match
);

	logic [ALLOWED_COUNT-1:0] hit;

	// per-entry compare, each entry and byte independent
	always_comb begin
		for (int e = 0; e < ALLOWED_COUNT; e++) begin
			hit[e] = (length_value == LENGTH_BITS'(ALLOWED_LEN[e]));
			for (int k = 0; k < OPCODE_BYTES; k++) begin
				if (k < int'(ALLOWED_LEN[e]) && store[k] != opc_char(e, k)) begin
					hit[e] = 1'b0;
				end
			end
		end
	end

	// an opcode longer than the store is never matched
	assign match.allowed = (|hit) && (length_value <= LENGTH_BITS'(OPCODE_BYTES));
	assign match.is_blob = hit[BLOB_ENTRY];

endmodule

### src/lpof_step.sv
// per-byte parser update: next state, opcode store write and result flags
// depends on lpof_pkg
module lpof_step
	import lpof_pkg::*;
(
	input  parse_state_t        cur,
	input  logic [7:0]          c,
	input  logic [CFG_BITS-1:0] element_limit,
	input  logic [CFG_BITS-1:0] blob_limit,
	input  opc_match_t          match,
	output parse_state_t        nxt,
	output store_wr_t           wr,
	output step_result_t        res
);

	logic [VAL_BITS-1:0]    base;
	logic [VAL_BITS-1:0]    value;
	logic [LENGTH_BITS-1:0] consumed_inc;
	logic                   is_digit;
	logic                   accepted;
	logic                   done;

	assign is_digit     = (c >= CH_ZERO) && (c <= CH_NINE);
	assign base         = cur.length_seen ? VAL_BITS'(cur.length_value) : '0;
	assign value        = (base << 3) + (base << 1) + VAL_BITS'(c - CH_ZERO);
	assign consumed_inc = cur.bytes_consumed + LENGTH_BITS'(1);

	// state update for one byte
	always_comb begin
		nxt      = cur;
		wr.we    = 1'b0;
		wr.idx   = cur.bytes_consumed[OPC_IDX_BITS-1:0];
		wr.data  = c;
		accepted = 1'b0;
		done     = 1'b0;
		if (cur.fault == ST_READY) begin
			unique case (cur.phase)
				PH_LENGTH: begin
					if (is_digit) begin
						nxt.length_seen = 1'b1;
						if (value > VAL_BITS'(element_limit) || value > LEN_MAX) begin
							nxt.fault = ST_INVALID;
						end else begin
							nxt.length_value = value[LENGTH_BITS-1:0];
						end
					end else if (c == CH_DOT) begin
						if (!cur.length_seen) begin
							nxt.fault = ST_INVALID;
						end else begin
							nxt.bytes_consumed = '0;
							if (cur.length_value == '0) begin
								nxt.phase = PH_DELIM;
							end else if (!cur.blob_limit_active || blob_limit == '0 ||
									VAL_BITS'(cur.length_value) <= VAL_BITS'(blob_limit)) begin
								nxt.phase = PH_DATA;
							end else begin
								nxt.fault = ST_INVALID;
							end
						end
					end else begin
						nxt.fault = ST_INVALID;
					end
				end
				PH_DATA: begin
					if (c[7]) begin
						nxt.fault = ST_INVALID;
					end else begin
						wr.we = cur.expecting_opcode &&
							(cur.bytes_consumed < LENGTH_BITS'(OPCODE_BYTES));
						nxt.bytes_consumed = consumed_inc;
						if (consumed_inc >= cur.length_value) begin
							nxt.phase = PH_DELIM;
						end
					end
				end
				default: begin
					if (c != CH_COMMA && c != CH_SEMI) begin
						nxt.fault = ST_INVALID;
					end else if (cur.expecting_opcode && !match.allowed) begin
						nxt.fault = ST_DENIED;
					end else begin
						if (cur.expecting_opcode) begin
							if (match.is_blob) begin
								nxt.blob_limit_active = 1'b1;
							end
							nxt.expecting_opcode = 1'b0;
							accepted = 1'b1;
						end
						if (c == CH_SEMI) begin
							done = 1'b1;
							nxt.expecting_opcode  = 1'b1;
							nxt.blob_limit_active = 1'b0;
						end
						nxt.length_seen  = 1'b0;
						nxt.length_value = '0;
						nxt.phase        = PH_LENGTH;
					end
				end
			endcase
		end
	end

	// status after the byte
	always_comb begin
		if (nxt.fault != ST_READY) begin
			res.status   = nxt.fault;
			res.accepted = 1'b0;
			res.done     = 1'b0;
		end else begin
			res.status   = (nxt.phase == PH_LENGTH && !nxt.length_seen) ? ST_READY : ST_PARSING;
			res.accepted = accepted;
			res.done     = done;
		end
	end

endmodule

### src/length_prefixed_opcode_filter.sv
// top level of the length-prefixed opcode filter: handshakes, state and result registers
// depends on lpof_pkg, lpof_opcode_match and lpof_step
//
// usage
//   input channel: in_valid / in_ready carry one stream byte per request,
//   with last_of_chunk as a marker that does not change the parse.
//   output channel: out_valid / out_ready carry one status per input byte:
//   parse_status (0 ready, 1 parsing, 2 invalid, 3 denied opcode),
//   opcode_accepted and instruction_done.
//   configuration: cfg_we writes cfg_data into register cfg_index
//   (0 element length limit, 1 blob argument limit); write only while idle.
// timing
//   a byte is captured in the input register, then the parser state and the
//   result register are updated together once the byte advances, so the status
//   is presented from the result register. one byte per cycle is sustained
//   while out_ready stays high; the rate is set by the state update loop.
// reset
//   arst_n clears the parser state, the handshakes and sets both limits to
//   4096. a fault is held until the next reset.
// stall
//   while out_ready is low the result register holds, one more byte can
//   wait in the input register, and in_ready then drops.
module length_prefixed_opcode_filter
	import lpof_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [CFG_IDX_BITS-1:0] cfg_index,
	input  logic [CFG_BITS-1:0]     cfg_data,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [7:0]              stream_byte,
	input  logic                    last_of_chunk,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [1:0]              parse_status,
	output logic                    opcode_accepted,
	output logic                    instruction_done
);

	logic [CFG_BITS-1:0] element_limit_q;
	logic [CFG_BITS-1:0] blob_limit_q;
	logic                valid_s1;
	logic [7:0]          byte_s1;
	logic                advance;
	parse_state_t        state_q;
	parse_state_t        state_nxt;
	opc_store_t          store_q;
	store_wr_t           wr;
	opc_match_t          match;
	step_result_t        res;
	step_result_t        res_s2;
	logic                valid_s2;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			element_limit_q <= LIMIT_RESET;
			blob_limit_q    <= LIMIT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ELEMENT_LIMIT: element_limit_q <= cfg_data;
				REG_BLOB_LIMIT:    blob_limit_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// handshake control
	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= stream_byte;
		end
	end

	// opcode compare and parser update
	lpof_opcode_match u_match (
		.store        (store_q),
		.length_value (state_q.length_value),
		.match        (match)
	);

	lpof_step u_step (
		.cur           (state_q),
		.c             (byte_s1),
		.element_limit (element_limit_q),
		.blob_limit    (blob_limit_q),
		.match         (match),
		.nxt           (state_nxt),
		.wr            (wr),
		.res           (res)
	);

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{
				phase:             PH_LENGTH,
				length_value:      '0,
				length_seen:       1'b0,
				bytes_consumed:    '0,
				expecting_opcode:  1'b1,
				blob_limit_active: 1'b0,
				fault:             ST_READY
			};
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// opcode byte store, meaningful only where written
	always_ff @(posedge clk) begin
		if (advance && wr.we) begin
			store_q[wr.idx] <= wr.data;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res;
		end
	end

	assign out_valid        = valid_s2;
	assign parse_status     = res_s2.status;
	assign opcode_accepted  = res_s2.accepted;
	assign instruction_done = res_s2.done;

	// a fault never clears without reset
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q.fault != ST_READY |=> $stable(state_q.fault))
		else $error("fault code changed after a fault");

	// a finished instruction always returns to the ready status
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && res_s2.done |-> res_s2.status == ST_READY)
		else $error("instruction done without ready status");

	// an accepted opcode ends at a delimiter, so the next length is not started yet
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && res_s2.accepted |-> res_s2.status == ST_READY)
		else $error("opcode accepted with wrong status");

	// the data phase only holds a nonempty element
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q.phase == PH_DATA |-> state_q.length_value != '0)
		else $error("data phase with zero length");

	// an accepted byte reaches the input register
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> valid_s1)
		else $error("accepted byte lost");

endmodule

### dv/tb_top.sv
`timescale 1ns / 1ps
// self-checking testbench for length_prefixed_opcode_filter: byte stream in, status out
// depends on lpof_pkg and the filter rtl; holds its own model of the parser to predict status

module tb_top;
	import lpof_pkg::*;

	// a fault never clears without reset, so all traffic is well formed
	// and one fault is provoked at the very end of the run
	typedef enum int {
		FK_NONDIGIT, FK_DOT_ONLY, FK_OVER_LIMIT, FK_BLOB_LONG, FK_EMPTY_OPCODE,
		FK_NON_ASCII, FK_LONG_OPCODE, FK_BAD_DELIM, FK_DENIED
	} fault_kind_e;

	typedef enum int {OP_DENIED, OP_ALLOWED, OP_BLOB} verdict_e;

	typedef struct packed {
		logic [7:0]   ch;
		logic         mark;
		logic         typed;
		step_result_t res;
	} script_row_t;

	localparam int QUIET_LIMIT = 4000;
	localparam int HOLD_CYCLES = 64;
	localparam int DRAIN_CYCLES = 8;

	localparam step_result_t NO_CHECK = '0;
	localparam step_result_t R_PARSE = '{ST_PARSING, 1'b0, 1'b0};
	localparam step_result_t R_OPC = '{ST_READY, 1'b1, 1'b0};
	localparam step_result_t R_DONE = '{ST_READY, 1'b0, 1'b1};

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    cfg_we = 1'b0;
	logic [CFG_IDX_BITS-1:0] cfg_index = REG_ELEMENT_LIMIT;
	logic [CFG_BITS-1:0]     cfg_data = '0;
	logic                    in_valid = 1'b0;
	logic                    in_ready;
	logic [7:0]              stream_byte = '0;
	logic                    last_of_chunk = 1'b0;
	logic                    out_valid;
	logic                    out_ready = 1'b0;
	logic [1:0]              parse_status;
	logic                    opcode_accepted;
	logic                    instruction_done;

	length_prefixed_opcode_filter dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.stream_byte(stream_byte),
		.last_of_chunk(last_of_chunk),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.parse_status(parse_status),
		.opcode_accepted(opcode_accepted),
		.instruction_done(instruction_done)
	);

	string op_names [18] = '{
		"key", "ack", "nop", "end", "size", "name", "argv", "sync", "blob",
		"audio", "video", "image", "mouse", "select", "connect", "timezone",
		"clipboard", "disconnect"
	};

	// directed opening: longest opcode, empty argument, data extremes 0 and 127
	script_row_t script [28] = '{
		'{"1", 1'b0, 1'b1, R_PARSE}, '{"0", 1'b0, 1'b1, R_PARSE},
		'{".", 1'b0, 1'b1, R_PARSE},
		'{"d", 1'b0, 1'b0, NO_CHECK}, '{"i", 1'b0, 1'b0, NO_CHECK},
		'{"s", 1'b0, 1'b0, NO_CHECK}, '{"c", 1'b0, 1'b0, NO_CHECK},
		'{"o", 1'b1, 1'b0, NO_CHECK}, '{"n", 1'b0, 1'b0, NO_CHECK},
		'{"n", 1'b0, 1'b0, NO_CHECK}, '{"e", 1'b0, 1'b0, NO_CHECK},
		'{"c", 1'b0, 1'b0, NO_CHECK}, '{"t", 1'b0, 1'b0, NO_CHECK},
		'{",", 1'b0, 1'b1, R_OPC},
		'{"0", 1'b0, 1'b0, NO_CHECK}, '{".", 1'b0, 1'b0, NO_CHECK},
		'{";", 1'b1, 1'b1, R_DONE},
		'{"3", 1'b0, 1'b0, NO_CHECK}, '{".", 1'b0, 1'b0, NO_CHECK},
		'{"a", 1'b0, 1'b0, NO_CHECK}, '{"c", 1'b0, 1'b0, NO_CHECK},
		'{"k", 1'b0, 1'b0, NO_CHECK}, '{",", 1'b0, 1'b1, R_OPC},
		'{"2", 1'b0, 1'b0, NO_CHECK}, '{".", 1'b0, 1'b0, NO_CHECK},
		'{8'h00, 1'b0, 1'b1, R_PARSE}, '{8'h7f, 1'b0, 1'b1, R_PARSE},
		'{";", 1'b1, 1'b1, R_DONE}
	};

	// parser model state and its copy of the limits
	phase_t                 flt_phase = PH_LENGTH;
	logic [LENGTH_BITS-1:0] flt_len = '0;
	logic                   flt_seen = 1'b0;
	logic [LENGTH_BITS-1:0] flt_consumed = '0;
	logic [7:0]             flt_store [OPCODE_BYTES];
	logic                   flt_want_opcode = 1'b1;
	logic                   flt_blob = 1'b0;
	status_t                flt_fault = ST_READY;
	logic [CFG_BITS-1:0]    lim_element = LIMIT_RESET;
	logic [CFG_BITS-1:0]    lim_blob = LIMIT_RESET;

	step_result_t pending_status [$];
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	bit hold_request = 1'b0;
	int hold_left = 0;
	int errors = 0;
	int bytes_sent = 0;
	int opcodes_seen = 0;
	int instructions_seen = 0;

	initial begin
		forever #1 clk = ~clk;
	end

	// whitelist lookup on the stored opcode bytes
	function automatic verdict_e opcode_verdict();
		bit hit;
		if (flt_len > OPCODE_BYTES) return OP_DENIED;
		for (int e = 0; e < 18; e++) begin
			if (op_names[e].len() == int'(flt_len)) begin
				hit = 1'b1;
				for (int k = 0; k < int'(flt_len); k++) begin
					if (flt_store[k] != op_names[e].getc(k)) hit = 1'b0;
				end
				if (hit) return (op_names[e] == "blob") ? OP_BLOB : OP_ALLOWED;
			end
		end
		return OP_DENIED;
	endfunction

	// advance the parser model by one byte and return the status it reports
	function automatic step_result_t next_status(input logic [7:0] c);
		step_result_t r;
		int unsigned v;
		verdict_e vd;
		r = '0;
		if (flt_fault == ST_READY) begin
			case (flt_phase)
				PH_LENGTH: begin
					if (c >= CH_ZERO && c <= CH_NINE) begin
						v = flt_seen ? flt_len : 0;
						v = v * 10 + (c - CH_ZERO);
						flt_seen = 1'b1;
						if (v > lim_element || v > (1 << LENGTH_BITS) - 1)
							flt_fault = ST_INVALID;
						else
							flt_len = v[LENGTH_BITS-1:0];
					end else if (c == CH_DOT) begin
						if (!flt_seen) begin
							flt_fault = ST_INVALID;
						end else begin
							flt_consumed = '0;
							if (flt_len == 0)
								flt_phase = PH_DELIM;
							else if (!flt_blob || lim_blob == 0 || flt_len <= lim_blob)
								flt_phase = PH_DATA;
							else
								flt_fault = ST_INVALID;
						end
					end else begin
						flt_fault = ST_INVALID;
					end
				end
				PH_DATA: begin
					if (c > 8'd127) begin
						flt_fault = ST_INVALID;
					end else begin
						if (flt_want_opcode && flt_consumed < OPCODE_BYTES)
							flt_store[flt_consumed] = c;
						flt_consumed = flt_consumed + 1'b1;
						if (flt_consumed >= flt_len) flt_phase = PH_DELIM;
					end
				end
				default: begin
					if (c != CH_COMMA && c != CH_SEMI) begin
						flt_fault = ST_INVALID;
					end else begin
						if (flt_want_opcode) begin
							vd = opcode_verdict();
							if (vd == OP_DENIED) begin
								flt_fault = ST_DENIED;
							end else begin
								if (vd == OP_BLOB) flt_blob = 1'b1;
								flt_want_opcode = 1'b0;
								r.accepted = 1'b1;
							end
						end
						if (flt_fault == ST_READY) begin
							if (c == CH_SEMI) begin
								r.done = 1'b1;
								flt_want_opcode = 1'b1;
								flt_blob = 1'b0;
							end
							flt_seen = 1'b0;
							flt_len = '0;
							flt_phase = PH_LENGTH;
						end
					end
				end
			endcase
		end
		if (flt_fault != ST_READY) begin
			r.status = flt_fault;
			r.accepted = 1'b0;
			r.done = 1'b0;
		end else if (flt_phase == PH_LENGTH && !flt_seen) begin
			r.status = ST_READY;
		end else begin
			r.status = ST_PARSING;
		end
		return r;
	endfunction

	// offer one byte, wait for its request to be taken, then log the expected status
	task automatic offer(input logic [7:0] b, input logic mark, input logic typed,
			input step_result_t given);
		step_result_t r;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		stream_byte <= b;
		last_of_chunk <= mark;
		do @(posedge clk); while (!in_ready);
		r = next_status(b);
		pending_status.push_back(typed ? given : r);
		bytes_sent++;
	endtask

	task automatic emit_byte(input logic [7:0] b);
		offer(b, ($urandom_range(0, 7) == 0), 1'b0, NO_CHECK);
	endtask

	task automatic emit_text(input string s);
		for (int i = 0; i < s.len(); i++) emit_byte(s.getc(i));
	endtask

	// decimal length with occasional leading zeros, then the dot
	task automatic emit_length(input int n);
		int zeros;
		zeros = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : 0;
		repeat (zeros) emit_byte(CH_ZERO);
		emit_text($sformatf("%0d.", n));
	endtask

	// one well-formed instruction: whitelisted opcode and up to three arguments
	task automatic emit_instruction();
		int op, nargs, top, n, r;
		string name;
		op = $urandom_range(0, 17);
		name = op_names[op];
		nargs = $urandom_range(0, 3);
		emit_length(name.len());
		emit_text(name);
		emit_byte(nargs == 0 ? CH_SEMI : CH_COMMA);
		for (int a = 0; a < nargs; a++) begin
			top = lim_element > 24 ? 24 : lim_element;
			if (name == "blob" && lim_blob != 0 && lim_blob < top) top = lim_blob;
			r = $urandom_range(0, 9);
			if (r < 7)
				n = $urandom_range(0, top < 6 ? top : 6);
			else if (r < 9)
				n = $urandom_range(0, top);
			else
				n = top;
			emit_length(n);
			repeat (n) emit_byte(8'($urandom_range(0, 127)));
			emit_byte(a == nargs - 1 ? CH_SEMI : CH_COMMA);
		end
	endtask

	// drop valid and wait until every status has come back
	task automatic wait_drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_status.size() != 0);
	endtask

	task automatic set_limits(input logic [CFG_BITS-1:0] element, input logic [CFG_BITS-1:0] blob);
		cfg_we <= 1'b1;
		cfg_index <= REG_ELEMENT_LIMIT;
		cfg_data <= element;
		@(posedge clk);
		cfg_index <= REG_BLOB_LIMIT;
		cfg_data <= blob;
		@(posedge clk);
		cfg_we <= 1'b0;
		lim_element = element;
		lim_blob = blob;
	endtask

	// receiver: random stalls plus one long hold-off on request
	initial begin
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
			end
		end
	end

	// compare each returned status with the oldest prediction
	always @(posedge clk) begin
		step_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_status.size() == 0) begin
				$error("unexpected status %0d with no request pending", parse_status);
				errors++;
			end else begin
				want = pending_status.pop_front();
				if (parse_status !== want.status) begin
					$error("parse_status: expected %0d, got %0d", want.status, parse_status);
					errors++;
				end
				if (opcode_accepted !== want.accepted) begin
					$error("opcode_accepted: expected %0d, got %0d", want.accepted,
						opcode_accepted);
					errors++;
				end
				if (instruction_done !== want.done) begin
					$error("instruction_done: expected %0d, got %0d", want.done,
						instruction_done);
					errors++;
				end
				if (opcode_accepted === 1'b1) opcodes_seen++;
				if (instruction_done === 1'b1) instructions_seen++;
			end
		end
	end

	// watchdog on cycles without any request moving
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("FAILURE");
		$finish;
	end

	// main sequence
	initial begin
		fault_kind_e fk;
		int phase_end;
		bit paused;
		logic [7:0] b;
		for (int k = 0; k < OPCODE_BYTES; k++) flt_store[k] = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed script at reset limits
		send_idle_pct = 27;
		recv_idle_pct = 80;
		foreach (script[i]) offer(script[i].ch, script[i].mark, script[i].typed, script[i].res);
		wait_drain();

		// widest element limit, blob limit off
		set_limits(16'hffff, 16'h0000);
		phase_end = bytes_sent + 450;
		while (bytes_sent < phase_end) emit_instruction();
		wait_drain();

		// tight limits, with one pause until all status is back
		send_idle_pct = 80;
		recv_idle_pct = 27;
		set_limits(16'd20, 16'd3);
		phase_end = bytes_sent + 450;
		paused = 1'b0;
		while (bytes_sent < phase_end) begin
			if (!paused && bytes_sent > phase_end - 225) begin
				wait_drain();
				paused = 1'b1;
			end
			emit_instruction();
		end
		wait_drain();

		// full rate, receiver holds off first so the input backs up
		send_idle_pct = 0;
		recv_idle_pct = 0;
		set_limits(LIMIT_RESET, 16'hffff);
		hold_request = 1'b1;
		phase_end = bytes_sent + 500;
		while (bytes_sent < phase_end) emit_instruction();
		wait_drain();

		// one terminal fault, then noise that must all echo the fault
		fk = fault_kind_e'($urandom_range(0, 8));
		set_limits(fk == FK_OVER_LIMIT ? 16'd0 : 16'd12, 16'd2);
		case (fk)
			FK_NONDIGIT: begin
				emit_byte("1");
				do b = 8'($urandom); while ((b >= CH_ZERO && b <= CH_NINE) || b == CH_DOT);
				emit_byte(b);
			end
			FK_DOT_ONLY: emit_byte(CH_DOT);
			FK_OVER_LIMIT: begin
				emit_byte(CH_ZERO);
				emit_byte(8'($urandom_range(1, 9)) + CH_ZERO);
			end
			FK_BLOB_LONG: emit_text("4.blob,3.");
			FK_EMPTY_OPCODE: emit_text("0.;");
			FK_NON_ASCII: begin
				emit_text("3.k");
				emit_byte(8'($urandom_range(128, 255)));
			end
			FK_LONG_OPCODE: emit_text("11.disconnects;");
			FK_BAD_DELIM: begin
				emit_text("3.key");
				do b = 8'($urandom); while (b == CH_COMMA || b == CH_SEMI);
				emit_byte(b);
			end
			default: emit_text("3.foo;");
		endcase
		emit_byte(8'hff);
		emit_byte(8'h00);
		repeat (24) emit_byte(8'($urandom));
		wait_drain();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("sent %0d stream bytes under five limit settings:", bytes_sent);
		$display("%0d opcodes accepted, %0d instructions done", opcodes_seen,
			instructions_seen);
		$display("closing fault case %s, %0d check errors", fk.name(), errors);
		if (errors == 0 && pending_status.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
